[design/linear_gradient_pixel_generator_top_defines.svh]
// ----------------------------------------------------------------------------
// Linear gradient pixel generator assertion macros
// Shared property wrappers for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LINEAR_GRADIENT_PIXEL_GENERATOR_TOP_DEFINES_SVH
`define LINEAR_GRADIENT_PIXEL_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define LGPG_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define LGPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/lgpg_pkg.sv]
// ----------------------------------------------------------------------------
// Linear gradient pixel generator package
// Widths, register indexes, gradient modes and the setup stage bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lgpg_pkg;

    // Field widths.
    localparam int POS_W     = 12;
    localparam int DIM_W     = 13;
    localparam int COLOR_W   = 8;
    localparam int RGB_W     = 24;
    localparam int CFG_IDX_W = 3;

    // Largest image dimension; larger register values saturate here.
    localparam int MAX_DIM = 4096;

    // Ramp arithmetic widths: t < 2^13, N <= 8192, t*|diff| < 2^21.
    localparam int T_W   = 13;
    localparam int N_W   = 14;
    localparam int NUM_W = 21;

    // One quotient bit per divider stage; the quotient never exceeds 255.
    localparam int DIV_STEPS = COLOR_W;

    // Ramp latency: multiply stage, divider stages, final add stage.
    localparam int RAMP_LAT = DIV_STEPS + 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END   = 3'd4;

    // Gradient direction.
    typedef enum logic [1:0] {
        MODE_HORIZ = 2'd0,
        MODE_VERT  = 2'd1,
        MODE_FALL  = 2'd2,
        MODE_RISE  = 2'd3
    } mode_t;

    // Ramp position, ramp length and out-of-image flag for one pixel.
    typedef struct packed {
        logic           oor;
        logic [T_W-1:0] t;
        logic [N_W-1:0] n;
    } term_t;

endpackage

[design/lgpg_setup.sv]
// ----------------------------------------------------------------------------
// Gradient setup stage
// Saturates the image size, flags positions outside the image and picks the
// ramp position t and ramp length N for the selected mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lgpg_setup (
    input  logic                         clk,
    input  logic [lgpg_pkg::POS_W-1:0]   pixel_row,
    input  logic [lgpg_pkg::POS_W-1:0]   pixel_col,
    input  lgpg_pkg::mode_t              gradient_mode,
    input  logic [lgpg_pkg::DIM_W-1:0]   image_cols,
    input  logic [lgpg_pkg::DIM_W-1:0]   image_rows,
    output lgpg_pkg::term_t              term
);

    import lgpg_pkg::*;

    logic [DIM_W-1:0] cols_sat;
    logic [DIM_W-1:0] rows_sat;
    logic [DIM_W-1:0] row_ext;
    logic [DIM_W-1:0] col_ext;
    logic [N_W-1:0]   diag_n;
    term_t            term_next;
    term_t            term_reg;

    // Clamp the configured size to the largest supported dimension.
    always_comb
    begin
        cols_sat = (image_cols > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_cols;
        rows_sat = (image_rows > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_rows;
        row_ext  = {1'b0, pixel_row};
        col_ext  = {1'b0, pixel_col};
        diag_n   = {1'b0, rows_sat} + {1'b0, cols_sat};
    end

    // Pick t and N; a zero size puts every position outside the image.
    always_comb
    begin
        term_next.oor = (row_ext >= rows_sat) || (col_ext >= cols_sat);
        unique case (gradient_mode)
            MODE_HORIZ:
            begin
                term_next.t = col_ext;
                term_next.n = {1'b0, cols_sat};
            end
            MODE_VERT:
            begin
                term_next.t = row_ext;
                term_next.n = {1'b0, rows_sat};
            end
            MODE_FALL:
            begin
                term_next.t = row_ext + col_ext;
                term_next.n = diag_n;
            end
            default:
            begin
                term_next.t = row_ext + (cols_sat - DIM_W'(1) - col_ext);
                term_next.n = diag_n;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        term_reg <= term_next;
    end

    assign term = term_reg;

endmodule

[design/lgpg_ramp.sv]
// ----------------------------------------------------------------------------
// Gradient channel ramp
// Computes start + floor(t * (end - start) / N) for one color channel with a
// multiply stage, a pipelined restoring divider and a final add stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lgpg_ramp (
    input  logic                          clk,
    input  logic [lgpg_pkg::T_W-1:0]      t,
    input  logic [lgpg_pkg::N_W-1:0]      n,
    input  logic [lgpg_pkg::COLOR_W-1:0]  start_val,
    input  logic [lgpg_pkg::COLOR_W-1:0]  end_val,
    output logic [lgpg_pkg::COLOR_W-1:0]  color
);

    import lgpg_pkg::*;

    logic                 neg_next;
    logic [COLOR_W-1:0]   mag_next;
    logic [NUM_W-1:0]     t_ext;
    logic [NUM_W-1:0]     mag_ext;
    logic [NUM_W-1:0]     num_next;

    // Stage 0 is the product; stage i+1 holds the result of divider step i.
    logic [NUM_W-1:0]     rem_reg [0:DIV_STEPS];
    logic [COLOR_W-1:0]   quo_reg [0:DIV_STEPS];
    logic [N_W-1:0]       n_reg   [0:DIV_STEPS];
    logic                 neg_reg [0:DIV_STEPS];

    logic [COLOR_W-1:0]   quo_adj;
    logic [COLOR_W-1:0]   delta;
    logic [COLOR_W-1:0]   color_next;
    logic [COLOR_W-1:0]   color_reg;

    // Magnitude and sign of the color difference, times the ramp position.
    always_comb
    begin
        neg_next = (end_val < start_val);
        mag_next = neg_next ? (start_val - end_val) : (end_val - start_val);
        t_ext    = NUM_W'(t);
        mag_ext  = NUM_W'(mag_next);
        num_next = t_ext * mag_ext;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num_next;
        quo_reg[0] <= '0;
        n_reg[0]   <= n;
        neg_reg[0] <= neg_next;
    end

    // One quotient bit per stage, most significant bit first.
    for (genvar gi = 0; gi < DIV_STEPS; gi++)
    begin : g_div
        localparam int K = DIV_STEPS - 1 - gi;

        logic [NUM_W-1:0] divisor;
        logic             fits;

        always_comb
        begin
            divisor = NUM_W'(n_reg[gi]) << K;
            fits    = (rem_reg[gi] >= divisor);
        end

        always_ff @(posedge clk)
        begin
            rem_reg[gi+1] <= fits ? (rem_reg[gi] - divisor) : rem_reg[gi];
            quo_reg[gi+1] <= quo_reg[gi] | (COLOR_W'(fits) << K);
            n_reg[gi+1]   <= n_reg[gi];
            neg_reg[gi+1] <= neg_reg[gi];
        end
    end

    // A falling ramp rounds toward minus infinity: negate the ceiling.
    always_comb
    begin
        quo_adj    = quo_reg[DIV_STEPS] +
                     COLOR_W'(rem_reg[DIV_STEPS] != '0);
        delta      = neg_reg[DIV_STEPS] ? (~quo_adj + COLOR_W'(1)) : quo_reg[DIV_STEPS];
        color_next = start_val + delta;
    end

    always_ff @(posedge clk)
    begin
        color_reg <= color_next;
    end

    assign color = color_reg;

endmodule

[design/linear_gradient_pixel_generator_top.sv]
// ----------------------------------------------------------------------------
// Linear gradient pixel generator
// Gives the RGB color of a linear gradient for one pixel position per clock.
// ----------------------------------------------------------------------------
//  Channel   Signals                                  Transfer when
//  -------   --------------------------------------   ---------------------
//  pixel in  start, busy, pixel_row, pixel_col        start && !busy
//  color out done, red_out, green_out, blue_out,      done (one cycle only)
//            out_of_range
//  config    cfg_wr_en, cfg_index, cfg_wdata          cfg_wr_en
//
//  A new pixel is taken every cycle; busy stays low.
//  A result reaches the outputs through the setup, multiply, eight divider
//  stages (one quotient bit each), add and output registers, the first
//  loaded at the transfer edge.
//  Reset clears the valid pipeline and loads the configuration defaults.
//  The receiver cannot stall, so results leave in order with no holding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "linear_gradient_pixel_generator_top_defines.svh"

module linear_gradient_pixel_generator_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [lgpg_pkg::POS_W-1:0]        pixel_row,
    input  logic [lgpg_pkg::POS_W-1:0]        pixel_col,
    output logic                              done,
    output logic [lgpg_pkg::COLOR_W-1:0]      red_out,
    output logic [lgpg_pkg::COLOR_W-1:0]      green_out,
    output logic [lgpg_pkg::COLOR_W-1:0]      blue_out,
    output logic                              out_of_range,
    input  logic                              cfg_wr_en,
    input  logic [lgpg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lgpg_pkg::RGB_W-1:0]        cfg_wdata
);

    import lgpg_pkg::*;

    mode_t                gradient_mode_reg;
    logic [DIM_W-1:0]     image_cols_reg;
    logic [DIM_W-1:0]     image_rows_reg;
    logic [RGB_W-1:0]     start_color_reg;
    logic [RGB_W-1:0]     end_color_reg;

    logic                 accept;
    term_t                term;
    logic [RAMP_LAT:0]    vld_pipe_reg;
    logic [RAMP_LAT-1:0]  oor_pipe_reg;
    logic                 oor_aligned;

    logic [COLOR_W-1:0]   ramp_red;
    logic [COLOR_W-1:0]   ramp_green;
    logic [COLOR_W-1:0]   ramp_blue;

    logic                 done_reg;
    logic [COLOR_W-1:0]   red_reg;
    logic [COLOR_W-1:0]   green_reg;
    logic [COLOR_W-1:0]   blue_reg;
    logic                 oor_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gradient_mode_reg <= MODE_HORIZ;
            image_cols_reg    <= DIM_W'(640);
            image_rows_reg    <= DIM_W'(480);
            start_color_reg   <= '0;
            end_color_reg     <= '1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MODE:  gradient_mode_reg <= mode_t'(cfg_wdata[1:0]);
                REG_COLS:  image_cols_reg    <= cfg_wdata[DIM_W-1:0];
                REG_ROWS:  image_rows_reg    <= cfg_wdata[DIM_W-1:0];
                REG_START: start_color_reg   <= cfg_wdata;
                REG_END:   end_color_reg     <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    // The pipeline takes a pixel every cycle.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Setup stage: saturation, range check, t and N.
    lgpg_setup u_setup (
        .clk           (clk),
        .pixel_row     (pixel_row),
        .pixel_col     (pixel_col),
        .gradient_mode (gradient_mode_reg),
        .image_cols    (image_cols_reg),
        .image_rows    (image_rows_reg),
        .term          (term)
    );

    // One ramp per color channel.
    lgpg_ramp u_ramp_red (
        .clk       (clk),
        .t         (term.t),
        .n         (term.n),
        .start_val (start_color_reg[23:16]),
        .end_val   (end_color_reg[23:16]),
        .color     (ramp_red)
    );

    lgpg_ramp u_ramp_green (
        .clk       (clk),
        .t         (term.t),
        .n         (term.n),
        .start_val (start_color_reg[15:8]),
        .end_val   (end_color_reg[15:8]),
        .color     (ramp_green)
    );

    lgpg_ramp u_ramp_blue (
        .clk       (clk),
        .t         (term.t),
        .n         (term.n),
        .start_val (start_color_reg[7:0]),
        .end_val   (end_color_reg[7:0]),
        .color     (ramp_blue)
    );

    // Valid bits follow the pixel through setup and the ramps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_pipe_reg <= '0;
        end
        else
        begin
            vld_pipe_reg <= {vld_pipe_reg[RAMP_LAT-1:0], accept};
        end
    end

    // The range flag is delayed to line up with the ramp outputs.
    always_ff @(posedge clk)
    begin
        oor_pipe_reg <= {oor_pipe_reg[RAMP_LAT-2:0], term.oor};
    end

    assign oor_aligned = oor_pipe_reg[RAMP_LAT-1];

    // Output register: positions outside the image give the start color.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_pipe_reg[RAMP_LAT];
        end
    end

    always_ff @(posedge clk)
    begin
        oor_reg   <= oor_aligned;
        red_reg   <= oor_aligned ? start_color_reg[23:16] : ramp_red;
        green_reg <= oor_aligned ? start_color_reg[15:8]  : ramp_green;
        blue_reg  <= oor_aligned ? start_color_reg[7:0]   : ramp_blue;
    end

    assign done         = done_reg;
    assign red_out      = red_reg;
    assign green_out    = green_reg;
    assign blue_out     = blue_reg;
    assign out_of_range = oor_reg;

    // Checks on the range logic and the ramp arithmetic.
    `LGPG_ASSERT_NEXT(a_row_outside_flagged,
        accept && (DIM_W'(pixel_row) >= image_rows_reg),
        term.oor,
        "row beyond the image was not flagged")

    `LGPG_ASSERT_IMPLY(a_outside_gives_start,
        done && out_of_range,
        (red_out == start_color_reg[23:16]) && (blue_out == start_color_reg[7:0]),
        "position outside the image did not give the start color")

    `LGPG_ASSERT_IMPLY(a_red_within_ramp,
        done && !out_of_range,
        ((red_out >= start_color_reg[23:16]) && (red_out <= end_color_reg[23:16])) ||
        ((red_out <= start_color_reg[23:16]) && (red_out >= end_color_reg[23:16])),
        "red channel left the range between start and end colors")

    `LGPG_ASSERT_IMPLY(a_flat_green,
        done && !out_of_range && (start_color_reg[15:8] == end_color_reg[15:8]),
        green_out == start_color_reg[15:8],
        "flat green ramp did not give the start value")

endmodule

[tb/lgpg_color_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear gradient pixel generator color checker
// Watches the pixel, color and register ports of the generator. It keeps a
// copy of the register file, works out the gradient color of every pixel
// transfer, and compares each color transfer with the oldest color still due.
// ----------------------------------------------------------------------------

module lgpg_color_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic [lgpg_pkg::POS_W-1:0]     pixel_row,
    input  logic [lgpg_pkg::POS_W-1:0]     pixel_col,
    input  logic                           done,
    input  logic [lgpg_pkg::COLOR_W-1:0]   red_out,
    input  logic [lgpg_pkg::COLOR_W-1:0]   green_out,
    input  logic [lgpg_pkg::COLOR_W-1:0]   blue_out,
    input  logic                           out_of_range,
    input  logic                           cfg_wr_en,
    input  logic [lgpg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lgpg_pkg::RGB_W-1:0]     cfg_wdata,
    output int                             error_count,
    output int                             pending,
    output int                             colors_checked,
    output int                             outside_seen
);

    import lgpg_pkg::*;

    // Register values after reset.
    localparam logic [DIM_W-1:0] COLS_AT_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] ROWS_AT_RESET  = 13'd480;
    localparam logic [RGB_W-1:0] START_AT_RESET = 24'h000000;
    localparam logic [RGB_W-1:0] END_AT_RESET   = 24'hFFFFFF;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               oor;
    } pixel_color_t;

    // Shadow copy of the register file.
    mode_t            grad_mode;
    logic [DIM_W-1:0] img_cols;
    logic [DIM_W-1:0] img_rows;
    logic [RGB_W-1:0] color_from;
    logic [RGB_W-1:0] color_to;

    // Colors owed by the generator, oldest first.
    pixel_color_t colors_due[$];

    // Dimension registers saturate at the largest image size.
    function automatic longint clamp_dim(input logic [DIM_W-1:0] d);
        return (d > MAX_DIM) ? longint'(MAX_DIM) : longint'(d);
    endfunction

    // One channel: from + floor(t * (to - from) / span), floor toward minus infinity.
    function automatic logic [COLOR_W-1:0] ramp_channel(input logic [COLOR_W-1:0] from,
                                                        input logic [COLOR_W-1:0] to,
                                                        input longint t,
                                                        input longint span);
        longint diff;
        longint num;
        longint q;
        diff = longint'(to) - longint'(from);
        num  = t * diff;
        if (num >= 0)
        begin
            q = num / span;
        end
        else
        begin
            q = -((-num + span - 1) / span);
        end
        return COLOR_W'(longint'(from) + q);
    endfunction

    // Gradient color of one pixel under the current register values.
    function automatic pixel_color_t gradient_color(input logic [POS_W-1:0] row,
                                                    input logic [POS_W-1:0] col);
        longint       rows;
        longint       cols;
        longint       r;
        longint       c;
        longint       t;
        longint       span;
        pixel_color_t px;
        rows = clamp_dim(img_rows);
        cols = clamp_dim(img_cols);
        r    = longint'(row);
        c    = longint'(col);
        if (r >= rows || c >= cols)
        begin
            px.red   = color_from[2*COLOR_W +: COLOR_W];
            px.green = color_from[COLOR_W +: COLOR_W];
            px.blue  = color_from[0 +: COLOR_W];
            px.oor   = 1'b1;
            return px;
        end
        case (grad_mode)
            MODE_HORIZ:
            begin
                t    = c;
                span = cols;
            end
            MODE_VERT:
            begin
                t    = r;
                span = rows;
            end
            MODE_FALL:
            begin
                t    = r + c;
                span = rows + cols;
            end
            default:
            begin
                t    = r + (cols - 1 - c);
                span = rows + cols;
            end
        endcase
        px.red   = ramp_channel(color_from[2*COLOR_W +: COLOR_W],
                                color_to[2*COLOR_W +: COLOR_W], t, span);
        px.green = ramp_channel(color_from[COLOR_W +: COLOR_W],
                                color_to[COLOR_W +: COLOR_W], t, span);
        px.blue  = ramp_channel(color_from[0 +: COLOR_W], color_to[0 +: COLOR_W], t, span);
        px.oor   = 1'b0;
        return px;
    endfunction

    // Sample all ports at the rising edge; inputs change only after it.
    always @(posedge clk or negedge rst_n)
    begin : watch_ports
        pixel_color_t want;
        pixel_color_t got;
        if (!rst_n)
        begin
            grad_mode  = MODE_HORIZ;
            img_cols   = COLS_AT_RESET;
            img_rows   = ROWS_AT_RESET;
            color_from = START_AT_RESET;
            color_to   = END_AT_RESET;
            colors_due.delete();
            error_count    = 0;
            colors_checked = 0;
            outside_seen   = 0;
            pending       <= 0;
        end
        else
        begin
            // Color transfer: compare with the oldest color due.
            if (done)
            begin
                got = '{red: red_out, green: green_out, blue: blue_out, oor: out_of_range};
                if (colors_due.size() == 0)
                begin
                    error_count++;
                    $display("%0t: color transfer with none due: r=%h g=%h b=%h oor=%b",
                             $time, got.red, got.green, got.blue, got.oor);
                end
                else
                begin
                    want = colors_due.pop_front();
                    colors_checked++;
                    if (want.oor)
                    begin
                        outside_seen++;
                    end
                    if (got !== want)
                    begin
                        error_count++;
                        $display({"%0t: color mismatch: expected r=%h g=%h b=%h oor=%b,",
                                  " actual r=%h g=%h b=%h oor=%b"},
                                 $time, want.red, want.green, want.blue, want.oor,
                                 got.red, got.green, got.blue, got.oor);
                    end
                end
            end

            // Pixel transfer: predict with the registers as they stand now.
            if (start && !busy)
            begin
                colors_due.push_back(gradient_color(pixel_row, pixel_col));
            end

            // Register write.
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_MODE:  grad_mode  = mode_t'(cfg_wdata[1:0]);
                    REG_COLS:  img_cols   = cfg_wdata[DIM_W-1:0];
                    REG_ROWS:  img_rows   = cfg_wdata[DIM_W-1:0];
                    REG_START: color_from = cfg_wdata;
                    REG_END:   color_to   = cfg_wdata;
                    default:   ;
                endcase
            end

            pending <= colors_due.size();
        end
    end

endmodule

[tb/linear_gradient_pixel_generator_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear gradient pixel generator testbench
// Drives pixel positions and register writes into the generator and leaves
// prediction and comparison to the color checker. A directed set covers the
// image corners, the edges just outside the image, zero and saturated sizes
// and rising, falling and flat ramps; random register settings and pixels
// follow, with the sender idling at several rates.
// ----------------------------------------------------------------------------

module linear_gradient_pixel_generator_top_test;

    import lgpg_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int SETTLE_CYCLES = RAMP_LAT + 8;
    localparam int RUN_LIMIT_NS  = 5_000_000;

    // Indexes that hold no register; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_END + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 start      = 1'b0;
    logic [POS_W-1:0]     pixel_row  = '0;
    logic [POS_W-1:0]     pixel_col  = '0;
    logic                 cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [RGB_W-1:0]     cfg_wdata  = '0;
    logic                 busy;
    logic                 done;
    logic [COLOR_W-1:0]   red_out;
    logic [COLOR_W-1:0]   green_out;
    logic [COLOR_W-1:0]   blue_out;
    logic                 out_of_range;

    int error_count;
    int pending;
    int colors_checked;
    int outside_seen;

    int sender_idle_pct = 0;
    int pixels_sent     = 0;
    int settings_used   = 0;
    int eff_rows        = 480;
    int eff_cols        = 640;

    always #CLK_HALF clk = ~clk;

    linear_gradient_pixel_generator_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pixel_row    (pixel_row),
        .pixel_col    (pixel_col),
        .done         (done),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .out_of_range (out_of_range),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    lgpg_color_checker color_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .pixel_row      (pixel_row),
        .pixel_col      (pixel_col),
        .done           (done),
        .red_out        (red_out),
        .green_out      (green_out),
        .blue_out       (blue_out),
        .out_of_range   (out_of_range),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .error_count    (error_count),
        .pending        (pending),
        .colors_checked (colors_checked),
        .outside_seen   (outside_seen)
    );

    // Stop the sender and wait until every color due has come out.
    task automatic drain_colors();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    // One pixel transfer, after a random number of idle cycles.
    task automatic send_pixel(input logic [POS_W-1:0] row, input logic [POS_W-1:0] col);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        pixel_row <= row;
        pixel_col <= col;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        pixels_sent++;
    endtask

    // Write all five registers back to back once the pipeline is empty,
    // sometimes followed by a write to an index that holds no register.
    task automatic apply_config(input logic [RGB_W-1:0] mode_w,
                                input logic [RGB_W-1:0] cols_w,
                                input logic [RGB_W-1:0] rows_w,
                                input logic [RGB_W-1:0] from_w,
                                input logic [RGB_W-1:0] to_w);
        drain_colors();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_MODE;
        cfg_wdata <= mode_w;
        @(posedge clk);
        cfg_index <= REG_COLS;
        cfg_wdata <= cols_w;
        @(posedge clk);
        cfg_index <= REG_ROWS;
        cfg_wdata <= rows_w;
        @(posedge clk);
        cfg_index <= REG_START;
        cfg_wdata <= from_w;
        @(posedge clk);
        cfg_index <= REG_END;
        cfg_wdata <= to_w;
        @(posedge clk);
        if ($urandom_range(0, 1) == 1)
        begin
            cfg_index <= CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST));
            cfg_wdata <= RGB_W'($urandom());
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        eff_cols = (cols_w[DIM_W-1:0] > MAX_DIM) ? MAX_DIM : int'(cols_w[DIM_W-1:0]);
        eff_rows = (rows_w[DIM_W-1:0] > MAX_DIM) ? MAX_DIM : int'(rows_w[DIM_W-1:0]);
        settings_used++;
    endtask

    // Image size word: mostly small images, with zero, one, full and
    // saturating sizes mixed in; the unused upper bits are sometimes set.
    function automatic logic [RGB_W-1:0] pick_dim_word();
        logic [DIM_W-1:0] d;
        logic [RGB_W-1:0] w;
        case ($urandom_range(0, 11))
            0:       d = '0;
            1:       d = DIM_W'(1);
            2:       d = DIM_W'(MAX_DIM);
            3:       d = DIM_W'($urandom_range(MAX_DIM + 1, (1 << DIM_W) - 1));
            4, 5:    d = DIM_W'($urandom_range(1, MAX_DIM));
            default: d = DIM_W'($urandom_range(1, 40));
        endcase
        w = RGB_W'(d);
        if ($urandom_range(0, 1) == 1)
        begin
            w[RGB_W-1:DIM_W] = (RGB_W - DIM_W)'($urandom());
        end
        return w;
    endfunction

    // Color word: black, white or any color.
    function automatic logic [RGB_W-1:0] pick_color();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return RGB_W'($urandom());
        endcase
    endfunction

    // Pixel coordinate: mostly inside the image, sometimes on or past its edge.
    function automatic logic [POS_W-1:0] pick_pos(input int dim);
        case ($urandom_range(0, 15))
            0:       return POS_W'($urandom());
            1:       return POS_W'(dim);
            2:       return POS_W'(dim - 1);
            3:       return '0;
            default: return (dim > 0) ? POS_W'($urandom_range(0, dim - 1)) : POS_W'($urandom());
        endcase
    endfunction

    // Random register setting; a flat ramp now and then.
    task automatic random_config();
        logic [RGB_W-1:0] mode_w;
        logic [RGB_W-1:0] from_w;
        logic [RGB_W-1:0] to_w;
        mode_w = RGB_W'($urandom_range(MODE_HORIZ, MODE_RISE));
        if ($urandom_range(0, 1) == 1)
        begin
            mode_w[RGB_W-1:2] = (RGB_W - 2)'($urandom());
        end
        from_w = pick_color();
        to_w   = ($urandom_range(0, 4) == 0) ? from_w : pick_color();
        apply_config(mode_w, pick_dim_word(), pick_dim_word(), from_w, to_w);
    endtask

    // Run limit.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Run limit reached with %0d colors still due.", pending);
        $display("DONE: errors detected");
        $finish;
    end

    // Stimulus.
    initial
    begin
        int idle_pcts[3];
        int phase;
        int left;
        int run_len;
        int k;

        idle_pcts = '{18, 80, 0};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Register values after reset: corners and just outside.
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd479, 12'd639);
        send_pixel(12'd480, 12'd0);
        send_pixel(12'd0, 12'd640);
        send_pixel(12'hFFF, 12'hFFF);

        // Falling diagonal; column count saturates; red falls, green rises, blue flat.
        apply_config(RGB_W'(MODE_FALL), 24'hFF1FFF, RGB_W'(MAX_DIM), 24'hFF0080, 24'h00FF80);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'hFFF, 12'd0);
        send_pixel(12'd2048, 12'd1234);

        // Rising diagonal on a one-pixel image.
        apply_config(RGB_W'(MODE_RISE), 24'd1, 24'd1, RGB_W'($urandom()), RGB_W'($urandom()));
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd0, 12'd1);
        send_pixel(12'd1, 12'd0);

        // Zero columns: every pixel lies outside; mode word has its upper bits set.
        apply_config(RGB_W'(MODE_VERT) | 24'hFFFFFC, 24'd0, 24'd100, 24'h123456, 24'hFEDCBA);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd50, 12'd0);

        // Zero rows.
        apply_config(RGB_W'(MODE_HORIZ), RGB_W'(MAX_DIM), 24'd0, 24'hA5A5A5, 24'h5A5A5A);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd0, 12'hFFF);

        // Full-size vertical ramp from black to white.
        apply_config(RGB_W'(MODE_VERT), RGB_W'(MAX_DIM), RGB_W'(MAX_DIM), 24'h000000, 24'hFFFFFF);
        send_pixel(12'hFFF, 12'd7);
        send_pixel(12'd0, 12'hFFF);

        // Full-size rising diagonal from white to black.
        apply_config(RGB_W'(MODE_RISE), RGB_W'(MAX_DIM), RGB_W'(MAX_DIM), 24'hFFFFFF, 24'h000000);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'd0, 12'hFFF);

        // Random settings in short runs, three sender idle rates.
        for (phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = idle_pcts[phase];
            left = RANDOM_ITEMS / 3;
            while (left > 0)
            begin
                random_config();
                run_len = $urandom_range(15, 60);
                for (k = 0; k < run_len && left > 0; k++)
                begin
                    send_pixel(pick_pos(eff_rows), pick_pos(eff_cols));
                    left--;
                    if ($urandom_range(0, 99) == 0)
                    begin
                        drain_colors();
                    end
                end
            end
        end

        drain_colors();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d colors from %0d pixels over %0d register settings, %0d outside the image.",
                 colors_checked, pixels_sent, settings_used, outside_seen);
        $display("Sender idle rates of 18, 80 and 0 percent; registers changed only when drained.");
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[linear_gradient_pixel_generator_top.f]
+incdir+design
design/lgpg_pkg.sv
design/lgpg_setup.sv
design/lgpg_ramp.sv
design/linear_gradient_pixel_generator_top.sv
tb/lgpg_color_checker.sv
tb/linear_gradient_pixel_generator_top_test.sv
